### hw/rtl/adqm_pkg.sv
// ----------------------------------------------------------------------------
// adqm_pkg - shared types and codes of the array deque
// Request modes, result status codes and the control codes that the
// controller sends down the chain of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package adqm_pkg;

  // request modes
  localparam logic [2:0] MODE_APPEND    = 3'd0;
  localparam logic [2:0] MODE_PREPEND   = 3'd1;
  localparam logic [2:0] MODE_DEL_LAST  = 3'd2;
  localparam logic [2:0] MODE_DEL_FIRST = 3'd3;
  localparam logic [2:0] MODE_DEL_MATCH = 3'd4;
  localparam logic [2:0] MODE_READ      = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam int DATA_W = 32;

  // operation broadcast to the whole chain
  typedef enum logic [2:0] {
    CH_HOLD,
    CH_APPEND,
    CH_PREPEND,
    CH_POP_FRONT,
    CH_WALK_KEEP,
    CH_WALK_DROP
  } chain_op_t;

  // per-cell action
  typedef enum logic [1:0] {
    CC_HOLD,
    CC_LOAD,
    CC_LOWER,
    CC_UPPER
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [DATA_W-1:0]   load;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/array_deque_with_match_removal_core.sv
// ----------------------------------------------------------------------------
// array_deque_with_match_removal_core - bounded deque of signed 32-bit values
// Controller and output register around a chain of entry cells.
// ----------------------------------------------------------------------------
// Append, prepend, delete last and delete first complete in the cycle the
// item is accepted, so they run at one item per cycle while the output side
// keeps up. Delete-all-matching and an in-range read rotate the list once
// through the cell chain in S_WALK, one entry per cycle, and no new item is
// taken while the walk runs; the result enters the output register from S_FIN
// once the rotation through the head cell is done. An add to a full list, a
// delete from an empty list, a read past the count and a delete-all on an
// empty list answer with no walk. Exactly one result item is returned per input item.
`default_nettype none

module array_deque_with_match_removal_core import adqm_pkg::*; #(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         mode,
  input  wire logic signed [31:0] value,
  input  wire logic [5:0]         index,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [6:0]              count,
  output logic signed [31:0]      read_value
);

  localparam int PW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     len;
  logic [CW-1:0]     step;
  logic [DATA_W-1:0] match_val;
  logic [5:0]        ridx;
  logic              is_read;
  logic [DATA_W-1:0] rd;

  logic              accept;
  logic              out_free;
  chain_op_t         ch_op;
  logic [PW-1:0]     ch_pos;
  logic [DATA_W-1:0] ch_din;
  logic [DATA_W-1:0] head;
  logic              keep;
  logic [CW-1:0]     len_next;
  logic              last_step;
  logic              full;
  logic              empty;
  logic              in_range;
  logic              go_walk;
  logic [1:0]        res_status;
  logic [CW-1:0]     cnt_next;
  logic              out_load;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // a new result item enters the output register this cycle
  assign out_load = ((state == S_IDLE) && accept && !go_walk) ||
                    ((state == S_FIN) && out_free);

  // list condition flags
  assign full     = (cnt == CW'(LIST_DEPTH));
  assign empty    = (cnt == '0);
  assign in_range = (XW'(index) < XW'(cnt));

  // walk step: head is kept unless it matches on a delete-all pass
  assign keep      = is_read || (head != match_val);
  assign len_next  = keep ? len : len - CW'(1);
  assign last_step = (step == cnt - CW'(1));

  // chain control and the results that need no walk
  always_comb begin
    ch_op      = CH_HOLD;
    ch_pos     = cnt[PW-1:0];
    ch_din     = value;
    res_status = ST_OK;
    cnt_next   = cnt;
    go_walk    = 1'b0;
    if (state == S_WALK) begin
      ch_op  = keep ? CH_WALK_KEEP : CH_WALK_DROP;
      ch_pos = PW'(len - CW'(1));
      ch_din = head;
    end else if (accept) begin
      case (mode)
        MODE_APPEND: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ch_op    = CH_APPEND;
            cnt_next = cnt + CW'(1);
          end
        end
        MODE_PREPEND: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ch_op    = CH_PREPEND;
            cnt_next = cnt + CW'(1);
          end
        end
        MODE_DEL_LAST: begin
          if (empty) res_status = ST_EMPTY;
          else       cnt_next   = cnt - CW'(1);
        end
        MODE_DEL_FIRST: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            ch_op    = CH_POP_FRONT;
            cnt_next = cnt - CW'(1);
          end
        end
        MODE_DEL_MATCH: begin
          go_walk = !empty;
        end
        MODE_READ: begin
          if (in_range) go_walk    = 1'b1;
          else          res_status = ST_RANGE;
        end
        default: ;
      endcase
    end
  end

  // controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            match_val <= value;
            ridx      <= index;
            is_read   <= (mode == MODE_READ);
            len       <= cnt;
            step      <= '0;
            rd        <= '0;
            if (go_walk) begin
              state <= S_WALK;
            end else begin
              cnt        <= cnt_next;
              out_valid  <= 1'b1;
              status     <= res_status;
              count      <= 7'(cnt_next);
              read_value <= '0;
            end
          end
        end
        S_WALK: begin
          step <= step + CW'(1);
          len  <= len_next;
          if (is_read && (XW'(step) == XW'(ridx))) rd <= head;
          if (last_step) begin
            cnt   <= len_next;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= ST_OK;
            count      <= 7'(cnt);
            read_value <= is_read ? rd : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  adqm_chain #(
    .DEPTH (LIST_DEPTH),
    .PW    (PW)
  ) u_chain (
    .clk  (clk),
    .op   (ch_op),
    .pos  (ch_pos),
    .din  (ch_din),
    .head (head)
  );

`ifndef SYNTHESIS
  // count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(LIST_DEPTH))
    else $error("entry count above capacity");

  // no item taken while a walk is running
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input not stalled during walk");

  // the active length never runs out inside a walk
  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((len != '0) && (step < cnt)))
    else $error("walk length or step out of range");

  // a delete-all on a non-empty list starts a walk
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_DEL_MATCH) && !empty) |=> (state == S_WALK))
    else $error("delete-all did not start a walk");

  // a walk ends in a result item
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_free) |=> (out_valid && (state == S_IDLE)))
    else $error("walk finished without a result");
`endif

endmodule

`default_nettype wire

### hw/rtl/adqm_cell.sv
// ----------------------------------------------------------------------------
// adqm_cell - one entry cell of the deque chain
// Holds one list entry and takes a new value from the broadcast load data,
// from its lower neighbor or from its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module adqm_cell import adqm_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [DATA_W-1:0] lower,
  input  wire logic [DATA_W-1:0] upper,
  output logic      [DATA_W-1:0] data
);

  // entry register
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CC_LOAD:  data <= ctl.load;
      CC_LOWER: data <= lower;
      CC_UPPER: data <= upper;
      default:  data <= data;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/adqm_chain.sv
// ----------------------------------------------------------------------------
// adqm_chain - row of entry cells
// Decodes the broadcast operation into one action per cell: shift up for
// prepend, shift down for pop and walk steps, load at one position.
// ----------------------------------------------------------------------------
`default_nettype none

module adqm_chain import adqm_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int PW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire chain_op_t         op,
  input  wire logic [PW-1:0]     pos,
  input  wire logic [DATA_W-1:0] din,
  output logic      [DATA_W-1:0] head
);

  logic [DATA_W-1:0] cell_q [DEPTH];
  cell_ctl_t         ctl    [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic              at_pos;
      logic [DATA_W-1:0] lower_d;
      logic [DATA_W-1:0] upper_d;

      assign at_pos = (pos == PW'(i));

      // neighbor data, tied off at both ends of the row
      if (i == 0) begin : g_first
        assign lower_d = '0;
      end else begin : g_mid_lo
        assign lower_d = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign upper_d = '0;
      end else begin : g_mid_hi
        assign upper_d = cell_q[i+1];
      end

      // per-cell action decode
      always_comb begin
        ctl[i].load = din;
        case (op)
          CH_APPEND:    ctl[i].cmd = at_pos ? CC_LOAD : CC_HOLD;
          CH_PREPEND:   ctl[i].cmd = (i == 0) ? CC_LOAD : CC_LOWER;
          CH_POP_FRONT: ctl[i].cmd = (i == DEPTH - 1) ? CC_HOLD : CC_UPPER;
          CH_WALK_KEEP: ctl[i].cmd = at_pos ? CC_LOAD :
                                     ((i == DEPTH - 1) ? CC_HOLD : CC_UPPER);
          CH_WALK_DROP: ctl[i].cmd = (i == DEPTH - 1) ? CC_HOLD : CC_UPPER;
          default:      ctl[i].cmd = CC_HOLD;
        endcase
      end

      adqm_cell u_cell (
        .clk   (clk),
        .ctl   (ctl[i]),
        .lower (lower_d),
        .upper (upper_d),
        .data  (cell_q[i])
      );
    end
  endgenerate

  assign head = cell_q[0];

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the bounded array deque
// Drives append, prepend, delete last, delete first, delete-all-matching and
// read requests, predicts every result in a scoreboard that keeps its own copy
// of the list, and compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import adqm_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ITEMS       = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  // modes with no operation behind them
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [6:0]  cnt;
    logic [31:0] rd;
  } deque_result_t;

  // list predictor and queue of results still owed by the block
  class deque_scoreboard;
    bit [31:0]     entries[DEPTH];
    int unsigned   held;
    deque_result_t owed_results[$];
    int            errors;
    int            requests;
    int            results;
    int            status_seen[4];
    int unsigned   deepest;

    function void note_request(logic [2:0] m, logic [31:0] v, logic [5:0] idx);
      deque_result_t r;
      int unsigned   i;
      int unsigned   kept;
      r.st = ST_OK;
      r.rd = '0;
      case (m)
        MODE_APPEND: begin
          if (held >= DEPTH) r.st = ST_FULL;
          else begin
            entries[held] = v;
            held++;
          end
        end
        MODE_PREPEND: begin
          if (held >= DEPTH) r.st = ST_FULL;
          else begin
            for (i = held; i > 0; i--) entries[i] = entries[i-1];
            entries[0] = v;
            held++;
          end
        end
        MODE_DEL_LAST: begin
          if (held == 0) r.st = ST_EMPTY;
          else held--;
        end
        MODE_DEL_FIRST: begin
          if (held == 0) r.st = ST_EMPTY;
          else begin
            for (i = 0; i + 1 < held; i++) entries[i] = entries[i+1];
            held--;
          end
        end
        MODE_DEL_MATCH: begin
          kept = 0;
          for (i = 0; i < held; i++) begin
            if (entries[i] != v) begin
              entries[kept] = entries[i];
              kept++;
            end
          end
          held = kept;
        end
        MODE_READ: begin
          if (idx >= held) r.st = ST_RANGE;
          else r.rd = entries[idx];
        end
        default: ;
      endcase
      r.cnt = 7'(held);
      if (held > deepest) deepest = held;
      status_seen[r.st]++;
      requests++;
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [6:0] cnt, logic [31:0] rd);
      deque_result_t want;
      results++;
      if (owed_results.size() == 0) begin
        $error("unexpected result item: status %0d count %0d read_value %0d",
               st, cnt, $signed(rd));
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (st !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, st);
        errors++;
      end
      if (cnt !== want.cnt) begin
        $error("count: expected %0d, got %0d", want.cnt, cnt);
        errors++;
      end
      if (rd !== want.rd) begin
        $error("read_value: expected %0d, got %0d", $signed(want.rd), $signed(rd));
        errors++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = MODE_APPEND;
  logic signed [31:0] value = '0;
  logic [5:0]         index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [6:0]         count;
  logic signed [31:0] read_value;

  deque_scoreboard sb = new();
  bit              steady = 1'b0;
  bit              hold_off_req = 1'b0;
  int              sent = 0;
  int              quiet_cycles = 0;
  int              hold_left = 0;

  array_deque_with_match_removal_core #(
    .LIST_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .value      (value),
    .index      (index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .count      (count),
    .read_value (read_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // note accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_request(mode, value, index);
    if (!rst && out_valid && !out_stall) sb.check_result(status, count, read_value);
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_off_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_off_req = 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 9);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("array_deque_with_match_removal_core: mismatch");
        $finish;
      end
    end
  end

  // offer one item, with an occasional gap before it
  task automatic offer_request(input logic [2:0] m, input logic [31:0] v,
                               input logic [5:0] idx);
    int gap;
    if (!steady && $urandom_range(99) < 9) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    index    <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop offering until every owed result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] pool[8];
    pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'd42};
    if ($urandom_range(3) == 0) return $urandom;
    return pool[$urandom_range(7)];
  endfunction

  function automatic logic [5:0] pick_index();
    if (sb.held > 0 && $urandom_range(3) != 0) return 6'($urandom_range(sb.held - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [2:0] pick_mode(burst_kind_t kind);
    int r;
    r = $urandom_range(99);
    case (kind)
      BURST_FILL: begin
        if (r < 45) return MODE_APPEND;
        if (r < 80) return MODE_PREPEND;
        if (r < 85) return MODE_DEL_LAST;
        if (r < 88) return MODE_DEL_FIRST;
        if (r < 93) return MODE_DEL_MATCH;
        return MODE_READ;
      end
      BURST_DRAIN: begin
        if (r < 30) return MODE_DEL_LAST;
        if (r < 60) return MODE_DEL_FIRST;
        if (r < 72) return MODE_DEL_MATCH;
        if (r < 80) return MODE_APPEND;
        if (r < 85) return MODE_PREPEND;
        return MODE_READ;
      end
      default: begin
        if (r < 18) return MODE_APPEND;
        if (r < 36) return MODE_PREPEND;
        if (r < 50) return MODE_DEL_LAST;
        if (r < 64) return MODE_DEL_FIRST;
        if (r < 76) return MODE_DEL_MATCH;
        if (r < 97) return MODE_READ;
        return (r < 99) ? MODE_SPARE_6 : MODE_SPARE_7;
      end
    endcase
  endfunction

  initial begin
    burst_kind_t kind;
    int          burst_len;
    bit          held_off;
    bit          paused;
    held_off = 1'b0;
    paused   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list corners and unused modes
    offer_request(MODE_READ,      32'h0, 6'd0);
    offer_request(MODE_DEL_LAST,  32'h0, 6'd0);
    offer_request(MODE_DEL_FIRST, 32'h0, 6'd0);
    offer_request(MODE_DEL_MATCH, 32'h0, 6'd0);
    offer_request(MODE_SPARE_6,   32'hFFFF_FFFF, 6'd63);
    offer_request(MODE_SPARE_7,   32'h1234_5678, 6'd21);
    // value extremes at both ends, then reads in and past range
    offer_request(MODE_APPEND,    32'h7FFF_FFFF, 6'd0);
    offer_request(MODE_PREPEND,   32'h8000_0000, 6'd0);
    offer_request(MODE_APPEND,    32'hFFFF_FFFF, 6'd0);
    offer_request(MODE_APPEND,    32'h0, 6'd0);
    offer_request(MODE_PREPEND,   32'hFFFF_FFFF, 6'd0);
    offer_request(MODE_READ,      32'h0, 6'd0);
    offer_request(MODE_READ,      32'h0, 6'd4);
    offer_request(MODE_READ,      32'h0, 6'd5);
    offer_request(MODE_READ,      32'h0, 6'd63);
    // match removal with several hits and with none
    offer_request(MODE_DEL_MATCH, 32'hFFFF_FFFF, 6'd0);
    offer_request(MODE_DEL_MATCH, 32'h0000_3039, 6'd0);
    offer_request(MODE_READ,      32'h0, 6'd1);
    offer_request(MODE_DEL_FIRST, 32'h0, 6'd0);
    offer_request(MODE_DEL_LAST,  32'h0, 6'd0);
    offer_request(MODE_DEL_LAST,  32'h0, 6'd0);
    offer_request(MODE_READ,      32'h0, 6'd0);
    wait_for_results();

    // random bursts that grow, shrink and churn the list
    while (sent < ITEMS) begin
      kind      = burst_kind_t'($urandom_range(2));
      burst_len = (kind == BURST_FILL) ? $urandom_range(60, 150) : $urandom_range(20, 100);
      repeat (burst_len) begin
        if (!held_off && sent >= 500) begin
          hold_off_req = 1'b1;
          held_off     = 1'b1;
        end
        if (!paused && sent >= 900) begin
          wait_for_results();
          paused = 1'b1;
        end
        steady = (sent >= 1100 && sent < 1300);
        offer_request(pick_mode(kind), pick_value(), pick_index());
      end
    end
    steady = 1'b0;

    // drain and watch for stray results
    wait_for_results();
    repeat (DEPTH + 8) @(posedge clk);

    $display("requests %0d, results %0d, deepest list %0d, mismatches %0d",
             sb.requests, sb.results, sb.deepest, sb.errors);
    $display("status mix: ok %0d, full %0d, empty %0d, out of range %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("array_deque_with_match_removal_core: match");
    end else begin
      $display("array_deque_with_match_removal_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
